### sv/cgr_pkg.sv
// shared types and constants for the cloth grid relaxation block
// no dependencies
`default_nettype none
package cgr_pkg;
    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_STEP = 2'd1,
        ACT_COLL = 2'd2,
        ACT_READ = 2'd3
    } action_t;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_START  = 3'd2;
    localparam logic [2:0] REG_KEEP   = 3'd3;
    localparam logic [2:0] REG_ACCEL  = 3'd4;
    localparam logic [2:0] REG_PAIR   = 3'd5;
    localparam logic [2:0] REG_SINGLE = 3'd6;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam int NB_COUNT = 16;

    typedef struct packed {
        logic signed [2:0] dx;
        logic signed [2:0] dy;
    } offset_t;

    function automatic offset_t nb_offset(input logic [3:0] k);
        offset_t o;
        unique case (k)
            4'd0:  o = '{3'sd1, 3'sd0};
            4'd1:  o = '{-3'sd1, 3'sd0};
            4'd2:  o = '{3'sd0, 3'sd1};
            4'd3:  o = '{3'sd0, -3'sd1};
            4'd4:  o = '{3'sd1, 3'sd1};
            4'd5:  o = '{3'sd1, -3'sd1};
            4'd6:  o = '{-3'sd1, 3'sd1};
            4'd7:  o = '{-3'sd1, -3'sd1};
            4'd8:  o = '{3'sd2, 3'sd0};
            4'd9:  o = '{-3'sd2, 3'sd0};
            4'd10: o = '{3'sd0, 3'sd2};
            4'd11: o = '{3'sd0, -3'sd2};
            4'd12: o = '{3'sd2, 3'sd2};
            4'd13: o = '{3'sd2, -3'sd2};
            4'd14: o = '{-3'sd2, 3'sd2};
            default: o = '{-3'sd2, -3'sd2};
        endcase
        return o;
    endfunction

    function automatic logic [16:0] clamp_coeff(input logic [16:0] r);
        return (r > ONE_Q16) ? ONE_Q16 : r;
    endfunction

    // q16 rounding, ties toward plus infinity (arithmetic shift of v + half)
    function automatic logic signed [49:0] round_q16(input logic signed [65:0] v);
        logic signed [65:0] x;
        x = v + 66'sd32768;
        return x[65:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -51'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

### sv/cgr_mac.sv
// shared multiply accumulate unit: signed 33 x 18 product added to accumulator
// depends on nothing beyond the ports
`default_nettype none
module cgr_mac
(
    input  wire logic               clk,
    input  wire logic               clr,
    input  wire logic               en,
    input  wire logic signed [32:0] a,
    input  wire logic        [16:0] b,
    output logic signed [65:0]      acc
);
    logic signed [50:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [65:0] acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg     <= a * $signed({1'b0, b});
        prod_vld_reg <= en;
        if (clr)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + 66'(prod_reg);
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

### sv/cloth_grid_relaxation_step.sv
// cloth grid relaxation block, top level: configuration, particle stores, sequencer
// depends on cgr_pkg and cgr_mac
//
// usage: one input item per in_valid/in_stall transfer, one result per item on
// the output channel; configuration writes go through cfg_valid/cfg_ready
// with a register index and data, taken only while the block is idle or
// clears the flag store after reset. load and read items address one
// particle. a step item walks the grid three times: integration,
// relaxation (one neighbour read per cycle from the snapshot memory into
// the shared multiply accumulate unit), and a max pass. a collision walks
// the grid once. in_stall is high while an item is in work and while the
// result waits. after reset the flag store is cleared in a pass during
// which no item is taken. if the receiver stalls, the result holds and no
// new item is taken.
`default_nettype none
module cloth_grid_relaxation_step
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [11:0]        particle_index,
    input  wire logic signed [31:0] terrain_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      position,
    output logic                    is_movable,
    output logic [30:0]             max_move,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH + 1) + 1;
    localparam int YW    = $clog2(MAX_HEIGHT + 1) + 1;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_LOAD  = 12'b000000000100,
        S_RDA   = 12'b000000001000,
        S_RDB   = 12'b000000010000,
        S_INTA  = 12'b000000100000,
        S_INTB  = 12'b000001000000,
        S_RLX   = 12'b000010000000,
        S_RLXW  = 12'b000100000000,
        S_MAXA  = 12'b001000000000,
        S_COLA  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]         width_reg, height_reg;
    logic signed [31:0] start_reg, accel_reg;
    logic [16:0]        keep_reg, pair_reg, single_reg;

    logic [AW-1:0] idx_reg;
    logic [AW:0]   cnt_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [4:0]    k_reg;
    logic [11:0]   pidx_reg;
    logic signed [31:0] tval_reg;
    logic signed [31:0] pos_out_reg;
    logic          mov_out_reg;
    logic [31:0]   best_reg;

    logic signed [31:0] cur_mem  [CELLS];
    logic signed [31:0] prev_mem [CELLS];
    logic signed [31:0] ter_mem  [CELLS];
    logic signed [31:0] snap_mem [CELLS];
    logic               flag_mem [CELLS];
    logic               nflag_mem [CELLS];

    logic signed [31:0] cur_rd, prev_rd, ter_rd, snap_rd, own_snap_reg;
    logic               flag_rd, nflag_rd;

    // effective sizes
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    logic [AW:0]   count;
    always_comb
    begin
        logic [6:0] wv, hv;
        wv = (width_reg < 7'd3) ? 7'd3 : width_reg;
        hv = (height_reg < 7'd3) ? 7'd3 : height_reg;
        w_eff = (XW'(wv) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(wv);
        h_eff = (YW'(hv) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(hv);
        count = (AW+1)'(w_eff) * (AW+1)'(h_eff);
    end

    // neighbour address
    cgr_pkg::offset_t off;
    logic signed [XW:0] nx;
    logic signed [YW:0] ny;
    logic               nb_in;
    logic [AW-1:0]      nb_addr;
    always_comb
    begin
        off   = cgr_pkg::nb_offset(k_reg[3:0]);
        nx    = $signed({1'b0, x_reg}) + (XW+1)'(off.dx);
        ny    = $signed({1'b0, y_reg}) + (YW+1)'(off.dy);
        nb_in = (nx >= 0) && (nx < $signed({1'b0, w_eff}))
              && (ny >= 0) && (ny < $signed({1'b0, h_eff}));
        nb_addr = AW'(ny[YW-1:0]) * AW'(w_eff) + AW'(nx[XW-1:0]);
    end

    // mac control
    logic               mac_clr, mac_en;
    logic signed [32:0] mac_a;
    logic [16:0]        mac_b;
    logic signed [65:0] mac_acc;
    logic               nb_vld_reg, nb_in_reg;

    cgr_mac u_mac
    (
        .clk (clk),
        .clr (mac_clr),
        .en  (mac_en),
        .a   (mac_a),
        .b   (mac_b),
        .acc (mac_acc)
    );

    always_comb
    begin
        mac_clr = 1'b0;
        mac_en  = 1'b0;
        mac_a   = $signed({cur_rd[31], cur_rd}) - $signed({prev_rd[31], prev_rd});
        mac_b   = cgr_pkg::clamp_coeff(keep_reg);
        if (state_reg == S_INTA)
            mac_clr = 1'b1;
        if (state_reg == S_RLX && k_reg == 5'd0)
            mac_clr = 1'b1;
        if (state_reg == S_RLX || state_reg == S_RLXW)
        begin
            mac_a  = $signed({snap_rd[31], snap_rd})
                   - $signed({own_snap_reg[31], own_snap_reg});
            mac_b  = nflag_rd ? cgr_pkg::clamp_coeff(pair_reg)
                              : cgr_pkg::clamp_coeff(single_reg);
            mac_en = nb_vld_reg && nb_in_reg;
        end
        if (state_reg == S_INTB && cnt_reg[1:0] == 2'd0)
            mac_en = 1'b1;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign out_valid = (state_reg == S_OUT);
    assign position   = pos_out_reg;
    assign is_movable = mov_out_reg;
    assign max_move   = (best_reg > 32'h7fffffff) ? 31'h7fffffff : best_reg[30:0];

    // memory reads (registered)
    logic [AW-1:0] rd_addr;
    always_comb
    begin
        rd_addr = idx_reg;
        if (state_reg == S_IDLE)
            rd_addr = AW'(particle_index);
    end

    always_ff @(posedge clk)
    begin
        cur_rd   <= cur_mem[rd_addr];
        prev_rd  <= prev_mem[rd_addr];
        ter_rd   <= ter_mem[rd_addr];
        flag_rd  <= flag_mem[rd_addr];
        snap_rd  <= snap_mem[nb_addr];
        nflag_rd <= nflag_mem[nb_addr];
        nb_in_reg  <= nb_in;
        nb_vld_reg <= (state_reg == S_RLX) && !k_reg[4];
    end

    // write controls for the load, step, collision and clear passes, one particle per pass counter step
    logic        do_load, do_int, do_rlx, do_col, do_clr, do_snap;
    logic signed [31:0] int_new, rlx_new;
    always_comb
    begin
        logic signed [49:0] vel;
        logic signed [49:0] corr;
        vel     = cgr_pkg::round_q16(mac_acc);
        int_new = cgr_pkg::sat32(51'(cur_rd) + 51'(vel) + 51'(accel_reg));
        corr    = cgr_pkg::round_q16(mac_acc);
        rlx_new = cgr_pkg::sat32(51'(cur_rd) + 51'(corr));
        do_load = (state_reg == S_LOAD) && (12'(idx_reg) == pidx_reg)
                && ({1'b0, pidx_reg} < 13'(count));
        do_int  = (state_reg == S_INTB) && (cnt_reg[1:0] == 2'd2);
        do_rlx  = (state_reg == S_RLXW) && cnt_reg[0] && flag_rd;
        do_col  = (state_reg == S_COLA) && cnt_reg[0];
        do_clr  = (state_reg == S_CLEAR);
        do_snap = do_int;
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            cur_mem[idx_reg]  <= start_reg;
            prev_mem[idx_reg] <= start_reg;
            ter_mem[idx_reg]  <= tval_reg;
        end
        else if (do_int && flag_rd)
        begin
            cur_mem[idx_reg]  <= int_new;
            prev_mem[idx_reg] <= cur_rd;
        end
        else if (do_rlx)
            cur_mem[idx_reg] <= rlx_new;
        else if (do_col && (cur_rd < ter_rd) && flag_rd)
            cur_mem[idx_reg] <= ter_rd;
        if (do_snap)
            snap_mem[idx_reg] <= flag_rd ? int_new : cur_rd;
    end

    always_ff @(posedge clk)
    begin
        if (do_clr)
        begin
            flag_mem[idx_reg]  <= 1'b0;
            nflag_mem[idx_reg] <= 1'b0;
        end
        else if (do_load)
        begin
            flag_mem[idx_reg]  <= 1'b1;
            nflag_mem[idx_reg] <= 1'b1;
        end
        else if (do_col && (cur_rd < ter_rd))
        begin
            flag_mem[idx_reg]  <= 1'b0;
            nflag_mem[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RLX && k_reg == 5'd0)
            own_snap_reg <= snap_mem[idx_reg];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
            start_reg  <= '0;
            keep_reg   <= cgr_pkg::ONE_Q16;
            accel_reg  <= '0;
            pair_reg   <= 17'd32768;
            single_reg <= cgr_pkg::ONE_Q16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cgr_pkg::REG_WIDTH:  width_reg  <= cfg_data[6:0];
                cgr_pkg::REG_HEIGHT: height_reg <= cfg_data[6:0];
                cgr_pkg::REG_START:  start_reg  <= cfg_data;
                cgr_pkg::REG_KEEP:   keep_reg   <= cfg_data[16:0];
                cgr_pkg::REG_ACCEL:  accel_reg  <= cfg_data;
                cgr_pkg::REG_PAIR:   pair_reg   <= cfg_data[16:0];
                cgr_pkg::REG_SINGLE: single_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // sequencer
    logic last;
    assign last = ({1'b0, idx_reg} == count - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (idx_reg == AW'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                begin
                    unique case (cgr_pkg::action_t'(action))
                        cgr_pkg::ACT_LOAD: state_next = S_LOAD;
                        cgr_pkg::ACT_STEP: state_next = S_INTA;
                        cgr_pkg::ACT_COLL: state_next = S_COLA;
                        default:           state_next = S_RDA;
                    endcase
                end
            S_LOAD:  state_next = S_OUT;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_OUT;
            S_INTA:  state_next = S_INTB;
            S_INTB:  if (cnt_reg[1:0] == 2'd2) state_next = last ? S_RLX : S_INTA;
            S_RLX:   if (k_reg == 5'd16) state_next = S_RLXW;
            S_RLXW:  if (cnt_reg[0]) state_next = last ? S_MAXA : S_RLX;
            S_MAXA:  if (cnt_reg[0] && last) state_next = S_OUT;
            S_COLA:  if (cnt_reg[0] && last) state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            best_reg    <= '0;
            pos_out_reg <= '0;
            mov_out_reg <= 1'b0;
            pidx_reg    <= '0;
            tval_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR: idx_reg <= idx_reg + 1'b1;
                S_IDLE:
                    if (in_valid)
                    begin
                        pidx_reg    <= particle_index;
                        tval_reg    <= terrain_value;
                        idx_reg     <= AW'(particle_index);
                        best_reg    <= '0;
                        pos_out_reg <= '0;
                        mov_out_reg <= 1'b0;
                        cnt_reg     <= '0;
                        k_reg       <= '0;
                        x_reg       <= '0;
                        y_reg       <= '0;
                        if (action != cgr_pkg::ACT_LOAD && action != cgr_pkg::ACT_READ)
                            idx_reg <= '0;
                    end
                S_RDB:
                    if ({1'b0, pidx_reg} < 13'(count) && 13'(idx_reg) == {1'b0, pidx_reg})
                    begin
                        pos_out_reg <= cur_rd;
                        mov_out_reg <= flag_rd;
                    end
                S_INTB:
                    if (cnt_reg[1:0] == 2'd2)
                    begin
                        cnt_reg <= '0;
                        idx_reg <= last ? '0 : idx_reg + 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                S_RLX:   k_reg <= k_reg + 1'b1;
                S_RLXW:
                    if (cnt_reg[0])
                    begin
                        cnt_reg <= '0;
                        k_reg   <= '0;
                        idx_reg <= last ? '0 : idx_reg + 1'b1;
                        if (x_reg == w_eff - 1'b1)
                        begin
                            x_reg <= '0;
                            y_reg <= y_reg + 1'b1;
                        end
                        else
                            x_reg <= x_reg + 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                S_MAXA:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[0])
                    begin
                        logic signed [32:0] d;
                        d = $signed({prev_rd[31], prev_rd}) - $signed({cur_rd[31], cur_rd});
                        if (d < 0)
                            d = -d;
                        if (flag_rd && 32'(d) > best_reg)
                            best_reg <= 32'(d);
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_COLA:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[0])
                        idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/cgr_checker.sv
// port-level checks for the cloth grid relaxation block, bound to the top level
// depends on cloth_grid_relaxation_step ports only
`default_nettype none
module cgr_props
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [30:0] max_move,
    input wire logic        cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(max_move))
        else $error("result changed while stalled");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result waits");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cfg_ready)
        else $error("configuration open during work");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block ready right after transfer");
endmodule

bind cloth_grid_relaxation_step cgr_props u_cgr_props
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .max_move  (max_move),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

### tb/sv/cgr_checker.sv
// checker for the cloth grid relaxation block: watches the config, input and result channels,
// keeps its own copy of the particle grid, predicts every result and compares field by field
// depends on cgr_pkg
`timescale 1ns / 100ps
module cgr_checker
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [11:0]        particle_index,
    input  wire logic signed [31:0] terrain_value,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [31:0] position,
    input  wire logic               is_movable,
    input  wire logic [30:0]        max_move,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      checked
);
    localparam int CELLS = 4096;
    localparam int DIM_MAX = 64;

    typedef struct {
        logic signed [31:0] pos;
        logic               movable;
        logic [30:0]        move;
    } particle_result_t;

    const int step_dx[16] = '{1, -1, 0, 0, 1, 1, -1, -1, 2, -2, 0, 0, 2, 2, -2, -2};
    const int step_dy[16] = '{0, 0, 1, -1, 1, -1, 1, -1, 0, 0, 2, -2, 2, -2, 2, -2};

    logic signed [31:0] cur_level [CELLS];
    logic signed [31:0] prev_level [CELLS];
    logic signed [31:0] ground [CELLS];
    logic signed [31:0] frozen_copy [CELLS];
    logic               free_cell [CELLS];

    logic [6:0]         width_reg, height_reg;
    logic signed [31:0] start_reg, accel_reg;
    logic [16:0]        keep_reg, pair_reg, single_reg;

    particle_result_t   expected_results [$];

    function automatic longint round_half_up(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int grid_dim(input logic [6:0] r);
        int v;
        v = r;
        if (v < 3)
            v = 3;
        if (v > DIM_MAX)
            v = DIM_MAX;
        return v;
    endfunction

    function automatic longint frac(input logic [16:0] r);
        longint v;
        v = r;
        return (v > 65536) ? 65536 : v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic grid_reset();
        width_reg = 7'd64;
        height_reg = 7'd64;
        start_reg = 0;
        keep_reg = cgr_pkg::ONE_Q16;
        accel_reg = 0;
        pair_reg = 17'd32768;
        single_reg = cgr_pkg::ONE_Q16;
        for (int i = 0; i < CELLS; i++)
        begin
            cur_level[i] = 0;
            prev_level[i] = 0;
            ground[i] = 0;
            frozen_copy[i] = 0;
            free_cell[i] = 0;
        end
        expected_results.delete();
    endtask

    task automatic predict_particle(input cgr_pkg::action_t act, input int idx,
                                    input logic signed [31:0] terrain,
                                    output particle_result_t res);
        int w, h, count, x, y, nx, ny, q;
        longint keep, acc, cp, cs, cur, sum, best, d;
        w = grid_dim(width_reg);
        h = grid_dim(height_reg);
        count = w * h;
        res.pos = 0;
        res.movable = 0;
        res.move = 0;
        case (act)
            cgr_pkg::ACT_LOAD:
            begin
                if (idx < count)
                begin
                    ground[idx] = terrain;
                    cur_level[idx] = start_reg;
                    prev_level[idx] = start_reg;
                    free_cell[idx] = 1;
                end
            end
            cgr_pkg::ACT_STEP:
            begin
                keep = frac(keep_reg);
                acc = accel_reg;
                cp = frac(pair_reg);
                cs = frac(single_reg);
                best = 0;
                for (int i = 0; i < count; i++)
                begin
                    if (free_cell[i])
                    begin
                        cur = cur_level[i];
                        cur_level[i] = clip32(cur + round_half_up((cur - prev_level[i]) * keep)
                                              + acc);
                        prev_level[i] = cur[31:0];
                    end
                end
                for (int i = 0; i < count; i++)
                    frozen_copy[i] = cur_level[i];
                for (int i = 0; i < count; i++)
                begin
                    if (free_cell[i])
                    begin
                        x = i % w;
                        y = i / w;
                        sum = 0;
                        for (int k = 0; k < 16; k++)
                        begin
                            nx = x + step_dx[k];
                            ny = y + step_dy[k];
                            if (nx >= 0 && nx < w && ny >= 0 && ny < h)
                            begin
                                q = ny * w + nx;
                                sum += (longint'(frozen_copy[q]) - longint'(frozen_copy[i]))
                                       * (free_cell[q] ? cp : cs);
                            end
                        end
                        cur_level[i] = clip32(longint'(cur_level[i]) + round_half_up(sum));
                    end
                end
                for (int i = 0; i < count; i++)
                begin
                    if (free_cell[i])
                    begin
                        d = longint'(prev_level[i]) - longint'(cur_level[i]);
                        if (d < 0)
                            d = -d;
                        if (d > best)
                            best = d;
                    end
                end
                if (best > 64'sd2147483647)
                    best = 64'sd2147483647;
                res.move = best[30:0];
            end
            cgr_pkg::ACT_COLL:
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (cur_level[i] < ground[i])
                    begin
                        if (free_cell[i])
                            cur_level[i] = ground[i];
                        free_cell[i] = 0;
                    end
                end
            end
            default:
            begin
                if (idx < count)
                begin
                    res.pos = cur_level[idx];
                    res.movable = free_cell[idx];
                end
            end
        endcase
    endtask

    initial
    begin
        fail_count = 0;
        checked = 0;
        grid_reset();
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        particle_result_t want;
        if (!rst_n)
            grid_reset();
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", position, 0);
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (position !== want.pos)
                        report_mismatch("position", position, want.pos);
                    if (is_movable !== want.movable)
                        report_mismatch("is_movable", is_movable, want.movable);
                    if (max_move !== want.move)
                        report_mismatch("max_move", max_move, want.move);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cgr_pkg::REG_WIDTH:  width_reg = cfg_data[6:0];
                    cgr_pkg::REG_HEIGHT: height_reg = cfg_data[6:0];
                    cgr_pkg::REG_START:  start_reg = cfg_data;
                    cgr_pkg::REG_KEEP:   keep_reg = cfg_data[16:0];
                    cgr_pkg::REG_ACCEL:  accel_reg = cfg_data;
                    cgr_pkg::REG_PAIR:   pair_reg = cfg_data[16:0];
                    cgr_pkg::REG_SINGLE: single_reg = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_particle(cgr_pkg::action_t'(action), particle_index, terrain_value,
                                 want);
                expected_results = {expected_results, want};
            end
        end
    end
endmodule

### tb/sv/cloth_grid_relaxation_step_test.sv
// top of the cloth grid relaxation testbench: clock, reset, stimulus and verdict
// depends on cgr_pkg, cgr_checker and the cloth_grid_relaxation_step block
`timescale 1ns / 100ps
module cloth_grid_relaxation_step_test;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD = 3000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [11:0]        particle_index;
    logic signed [31:0] terrain_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] position;
    logic               is_movable;
    logic [30:0]        max_move;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    int fail_count, pending, checked;
    int cycles;
    int items_sent;
    int phases_run;
    bit quiet;
    bit hold_req;

    cloth_grid_relaxation_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .particle_index(particle_index), .terrain_value(terrain_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .position(position), .is_movable(is_movable), .max_move(max_move),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cgr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .particle_index(particle_index), .terrain_value(terrain_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .position(position), .is_movable(is_movable), .max_move(max_move),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
        clk = 0;

    always #10 clk = ~clk;

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random hold-offs, one long stretch on request
    initial
    begin
        int n;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                n = LONG_HOLD;
                hold_req = 0;
            end
            else
                n = quiet ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input cgr_pkg::action_t act, input int idx,
                             input logic signed [31:0] t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        action <= act;
        particle_index <= idx[11:0];
        terrain_value <= t;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic signed [31:0] near_level(input logic signed [31:0] base);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, 2097152)) - 64'sd1048576;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic run_phase(input logic [6:0] wr, input logic [6:0] hr,
                             input logic signed [31:0] st, input logic [16:0] kp,
                             input logic signed [31:0] ac, input logic [16:0] pr,
                             input logic [16:0] sg, input int n_random, input bit long_hold);
        int w, h, count, r, idx;
        logic signed [31:0] t;
        // idle before touching registers
        @(negedge clk);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(cgr_pkg::REG_WIDTH, {25'd0, wr});
        write_reg(cgr_pkg::REG_HEIGHT, {25'd0, hr});
        write_reg(cgr_pkg::REG_START, st);
        write_reg(cgr_pkg::REG_KEEP, {15'd0, kp});
        write_reg(cgr_pkg::REG_ACCEL, ac);
        write_reg(cgr_pkg::REG_PAIR, {15'd0, pr});
        write_reg(cgr_pkg::REG_SINGLE, {15'd0, sg});
        write_reg(REG_UNUSED, $urandom);
        w = (wr < 3) ? 3 : (wr > 64) ? 64 : wr;
        h = (hr < 3) ? 3 : (hr > 64) ? 64 : hr;
        count = w * h;
        phases_run++;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                t = 32'sh7fffffff;
            else if (i == 1)
                t = 32'sh80000000;
            else
                t = ($urandom_range(0, 7) == 0) ? $urandom : near_level(st);
            send_item(cgr_pkg::ACT_LOAD, i, t);
        end
        // special cases: outside the grid, both ends of the grid
        send_item(cgr_pkg::ACT_READ, 4095, 0);
        send_item(cgr_pkg::ACT_LOAD, $urandom_range(count, 4095), $urandom);
        send_item(cgr_pkg::ACT_STEP, 0, 0);
        send_item(cgr_pkg::ACT_READ, 0, 0);
        send_item(cgr_pkg::ACT_COLL, 0, 0);
        send_item(cgr_pkg::ACT_READ, count - 1, 0);
        send_item(cgr_pkg::ACT_STEP, 0, 0);
        if (long_hold)
            hold_req = 1;
        for (int n = 0; n < n_random; n++)
        begin
            r = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(count, 4095)
                                               : $urandom_range(0, count - 1);
            t = ($urandom_range(0, 3) == 0) ? $urandom : near_level(st);
            if (r < 35)
                send_item(cgr_pkg::ACT_STEP, $urandom, $urandom);
            else if (r < 50)
                send_item(cgr_pkg::ACT_COLL, $urandom, $urandom);
            else if (r < 75)
                send_item(cgr_pkg::ACT_READ, idx, $urandom);
            else
                send_item(cgr_pkg::ACT_LOAD, idx, t);
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        action = cgr_pkg::ACT_LOAD;
        particle_index = 0;
        terrain_value = 0;
        cfg_valid = 0;
        cfg_index = cgr_pkg::REG_WIDTH;
        cfg_data = 0;
        quiet = 0;
        hold_req = 0;
        items_sent = 0;
        phases_run = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        run_phase(7'd0, 7'd2, 32'sd0, 17'd65536, -32'sd32768, 17'd32768, 17'd65536, 6, 0);
        run_phase(7'd4, 7'd3, $urandom, 17'd0, 32'sh7fffffff, 17'h1ffff, 17'd0, 6, 1);
        run_phase(7'd3, 7'd4, 32'sh80000000, 17'h1ffff, 32'sh80000000, 17'd0, 17'd65536,
                  6, 0);
        quiet = 1;
        run_phase(7'd4, 7'd4, $urandom, $urandom_range(0, 131071), $signed($urandom) >>> 8,
                  $urandom_range(0, 131071), $urandom_range(0, 131071), 6, 0);
        quiet = 0;

        @(negedge clk);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d items over %0d grid settings, %0d results checked",
                 items_sent, phases_run, checked);
        $display("loads, steps, collisions and reads with out-of-grid indexes and clamped sizes");
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
